@@ rtl/weighted_graph_adjacency_table_macros.svh @@
// Assertion helpers shared by the graph table modules
`ifndef WEIGHTED_GRAPH_ADJACENCY_TABLE_MACROS_SVH
`define WEIGHTED_GRAPH_ADJACENCY_TABLE_MACROS_SVH

// same-cycle implication
`define WGAT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WGAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/wgat_pkg.sv @@
`timescale 1ns / 1ps

package wgat_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int KEY_BITS     = 32;
   localparam int WEIGHT_BITS  = 16;

   localparam int VIDX_BITS   = $clog2(MAX_VERTICES);
   localparam int CNT_BITS    = $clog2(MAX_VERTICES + 1);
   localparam int ADDR_BITS   = 2 * VIDX_BITS;
   localparam int MEM_DEPTH   = 1 << ADDR_BITS;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_ADD_VERTEX  = 3'd0,
      CMD_SET_EDGE    = 3'd1,
      CMD_READ_WEIGHT = 3'd2,
      CMD_LIST        = 3'd3,
      CMD_CLEAR_MARKS = 3'd4,
      CMD_MARK        = 3'd5,
      CMD_TEST_MARK   = 3'd6,
      CMD_RESET_GRAPH = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type                        command;
      logic [KEY_BITS-1:0]            key_a;
      logic [KEY_BITS-1:0]            key_b;
      logic signed [WEIGHT_BITS-1:0]  edge_weight;
   } req_type;

   typedef struct packed {
      status_type                     status;
      logic signed [WEIGHT_BITS-1:0]  weight_out;
      logic                           is_marked;
      logic [KEY_BITS-1:0]            neighbour_key;
      logic                           neighbour_valid;
      logic                           last;
   } rsp_type;

   typedef struct packed {
      cmd_type                        command;
      status_type                     status;
      logic [VIDX_BITS-1:0]           ra;
      logic [VIDX_BITS-1:0]           rb;
      logic signed [WEIGHT_BITS-1:0]  weight;
      logic [CNT_BITS-1:0]            count;
   } op_type;

endpackage

@@ rtl/wgat_front.sv @@
`timescale 1ns / 1ps
`include "weighted_graph_adjacency_table_macros.svh"

module wgat_front
   import wgat_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  req_type              req_data,
   output logic                 busy,
   input  logic                 queue_full,
   output logic                 push,
   output op_type               op,
   input  logic                 list_done,
   input  logic [VIDX_BITS-1:0] key_idx,
   output logic [KEY_BITS-1:0]  key_data
);

   logic [KEY_BITS-1:0]     keys_ff [MAX_VERTICES];
   logic [CNT_BITS-1:0]     count_ff;
   logic [CNT_BITS-1:0]     count_in;
   logic                    list_busy_ff;
   logic                    list_busy_in;
   logic [MAX_VERTICES-1:0] hit_a;
   logic [MAX_VERTICES-1:0] hit_b;
   logic [VIDX_BITS-1:0]    ra;
   logic [VIDX_BITS-1:0]    rb;
   logic                    found_a;
   logic                    found_b;
   logic                    full;
   logic                    add_ok;

   assign busy     = queue_full | list_busy_ff;
   assign push     = start & ~busy;
   assign full     = (count_ff == CNT_BITS'(MAX_VERTICES));
   assign add_ok   = push && (req_data.command == CMD_ADD_VERTEX) && !full;
   assign key_data = keys_ff[key_idx];
   assign found_a  = |hit_a;
   assign found_b  = |hit_b;

   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         hit_a[i] = (CNT_BITS'(i) < count_ff) && (keys_ff[i] == req_data.key_a);
         hit_b[i] = (CNT_BITS'(i) < count_ff) && (keys_ff[i] == req_data.key_b);
      end
   end

   // first match wins
   always_comb begin
      ra = '0;
      rb = '0;
      for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
         if (hit_a[i]) begin
            ra = VIDX_BITS'(i);
         end
         if (hit_b[i]) begin
            rb = VIDX_BITS'(i);
         end
      end
   end

   always_comb begin
      op.command = req_data.command;
      op.ra      = ra;
      op.rb      = rb;
      op.weight  = req_data.edge_weight;
      op.count   = count_ff;
      unique case (req_data.command) inside
         CMD_ADD_VERTEX: begin
            op.status = full ? ST_FULL : ST_OK;
         end
         CMD_SET_EDGE, CMD_READ_WEIGHT: begin
            op.status = (found_a && found_b) ? ST_OK : ST_NOT_FOUND;
         end
         CMD_LIST, CMD_MARK, CMD_TEST_MARK: begin
            op.status = found_a ? ST_OK : ST_NOT_FOUND;
         end
         default: begin
            op.status = ST_OK;
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      list_busy_in = list_busy_ff;
      if (add_ok) begin
         count_in = count_ff + 1'b1;
      end else if (push && (req_data.command == CMD_RESET_GRAPH)) begin
         count_in = '0;
      end
      if (push && (req_data.command == CMD_LIST)) begin
         list_busy_in = 1'b1;
      end else if (list_done) begin
         list_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         list_busy_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         list_busy_ff <= list_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (add_ok) begin
         keys_ff[count_ff[VIDX_BITS-1:0]] <= req_data.key_a;
      end
   end

   `WGAT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_BITS'(MAX_VERTICES), "vertex count beyond table size")
   `WGAT_ASSERT_NEXT(a_list_blocks, clock, reset, push && (req_data.command == CMD_LIST), busy, "list transfer did not block input")
   `WGAT_ASSERT_NEXT(a_add_counts, clock, reset, add_ok, count_ff == $past(count_ff) + 1'b1, "add vertex did not advance count")

endmodule

@@ rtl/wgat_queue.sv @@
`timescale 1ns / 1ps

module wgat_queue
   import wgat_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_data,
   input  logic   pop,
   output op_type pop_data,
   output logic   empty,
   output logic   full
);

   op_type                 entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff;
   logic [QPTR_BITS-1:0]   rd_ptr_ff;
   logic [QCNT_BITS-1:0]   fill_ff;

   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   fill_ff <= fill_ff + 1'b1;
            2'b01:   fill_ff <= fill_ff - 1'b1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/wgat_back.sv @@
`timescale 1ns / 1ps
`include "weighted_graph_adjacency_table_macros.svh"

module wgat_back
   import wgat_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic signed [WEIGHT_BITS-1:0] csr_data,
   input  logic                          op_valid,
   input  op_type                        op,
   output logic                          pop,
   output logic                          list_done,
   output logic [VIDX_BITS-1:0]          key_idx,
   input  logic [KEY_BITS-1:0]           key_data,
   output logic                          rsp_valid,
   output rsp_type                       rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SET2,
      S_READ,
      S_LIST,
      S_LIST_END
   } state_type;

   state_type                     state_ff, state_in;
   op_type                        cur_ff, cur_in;
   logic [VIDX_BITS-1:0]          jd_ff, jd_in;
   logic                          pend_ff, pend_in;
   logic [KEY_BITS-1:0]           pend_key_ff, pend_key_in;
   logic signed [WEIGHT_BITS-1:0] null_ff, null_in;
   logic signed [WEIGHT_BITS-1:0] fill_ff, fill_in;
   logic [MEM_DEPTH-1:0]          valid_ff, valid_in;
   logic [MAX_VERTICES-1:0]       marks_ff, marks_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_ff, rsp_in;

   logic signed [WEIGHT_BITS-1:0] weight_mem [MEM_DEPTH];
   logic signed [WEIGHT_BITS-1:0] rd_data_ff;
   logic                          rd_valid_ff;
   logic signed [WEIGHT_BITS-1:0] rd_weight;
   logic                          mem_we;
   logic [ADDR_BITS-1:0]          mem_waddr;
   logic signed [WEIGHT_BITS-1:0] mem_wdata;
   logic                          mem_re;
   logic [ADDR_BITS-1:0]          mem_raddr;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign key_idx   = jd_ff;
   assign rd_weight = rd_valid_ff ? rd_data_ff : fill_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      jd_in        = jd_ff;
      pend_in      = pend_ff;
      pend_key_in  = pend_key_ff;
      null_in      = csr_valid ? csr_data : null_ff;
      fill_in      = fill_ff;
      valid_in     = valid_ff;
      marks_in     = marks_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.last  = 1'b1;
      pop          = 1'b0;
      list_done    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = {cur_ff.ra, cur_ff.rb};
      mem_wdata    = cur_ff.weight;
      mem_re       = 1'b0;
      mem_raddr    = {cur_ff.ra, jd_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               pop    = 1'b1;
               cur_in = op;
               if (op.status != ST_OK) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = op.status;
                  list_done     = (op.command == CMD_LIST);
               end else begin
                  unique case (op.command)
                     CMD_ADD_VERTEX: begin
                        rsp_valid_in = 1'b1;
                     end
                     CMD_SET_EDGE: begin
                        mem_we    = 1'b1;
                        mem_waddr = {op.ra, op.rb};
                        mem_wdata = op.weight;
                        state_in  = S_SET2;
                     end
                     CMD_READ_WEIGHT: begin
                        mem_re    = 1'b1;
                        mem_raddr = {op.ra, op.rb};
                        state_in  = S_READ;
                     end
                     CMD_LIST: begin
                        if (op.count == '0) begin
                           rsp_valid_in = 1'b1;
                           list_done    = 1'b1;
                        end else begin
                           mem_re    = 1'b1;
                           mem_raddr = {op.ra, VIDX_BITS'(0)};
                           jd_in     = '0;
                           pend_in   = 1'b0;
                           state_in  = S_LIST;
                        end
                     end
                     CMD_CLEAR_MARKS: begin
                        marks_in     = '0;
                        rsp_valid_in = 1'b1;
                     end
                     CMD_MARK: begin
                        marks_in[op.ra] = 1'b1;
                        rsp_valid_in    = 1'b1;
                     end
                     CMD_TEST_MARK: begin
                        rsp_in.is_marked = marks_ff[op.ra];
                        rsp_valid_in     = 1'b1;
                     end
                     CMD_RESET_GRAPH: begin
                        valid_in     = '0;
                        fill_in      = null_ff;
                        marks_in     = '0;
                        rsp_valid_in = 1'b1;
                     end
                     default: begin
                        rsp_valid_in = 1'b1;
                     end
                  endcase
               end
            end
         end
         S_SET2: begin
            mem_we       = 1'b1;
            mem_waddr    = {cur_ff.rb, cur_ff.ra};
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_READ: begin
            rsp_in.weight_out = rd_weight;
            rsp_valid_in      = 1'b1;
            state_in          = S_IDLE;
         end
         S_LIST: begin
            if (rd_weight != null_ff) begin
               if (pend_ff) begin
                  rsp_valid_in           = 1'b1;
                  rsp_in.neighbour_key   = pend_key_ff;
                  rsp_in.neighbour_valid = 1'b1;
                  rsp_in.last            = 1'b0;
               end
               pend_in     = 1'b1;
               pend_key_in = key_data;
            end
            if (CNT_BITS'(jd_ff) == CNT_BITS'(cur_ff.count - 1'b1)) begin
               state_in = S_LIST_END;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = {cur_ff.ra, jd_ff + 1'b1};
               jd_in     = jd_ff + 1'b1;
            end
         end
         S_LIST_END: begin
            rsp_valid_in           = 1'b1;
            rsp_in.neighbour_key   = pend_ff ? pend_key_ff : '0;
            rsp_in.neighbour_valid = pend_ff;
            pend_in                = 1'b0;
            list_done              = 1'b1;
            state_in               = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (mem_we) begin
         valid_in[mem_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         null_ff      <= '0;
         fill_ff      <= '0;
         valid_ff     <= '0;
         marks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         null_ff      <= null_in;
         fill_ff      <= fill_in;
         valid_ff     <= valid_in;
         marks_ff     <= marks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      jd_ff       <= jd_in;
      pend_key_ff <= pend_key_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         weight_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff  <= weight_mem[mem_raddr];
         rd_valid_ff <= valid_ff[mem_raddr];
      end
   end

   `WGAT_ASSERT_NOW(a_mid_is_neighbour, clock, reset, rsp_valid_ff && !rsp_ff.last, rsp_ff.neighbour_valid, "non-final result without neighbour")
   `WGAT_ASSERT_NOW(a_error_alone, clock, reset, rsp_valid_ff && (rsp_ff.status != ST_OK), rsp_ff.last && !rsp_ff.neighbour_valid, "error result not final")
   `WGAT_ASSERT_NEXT(a_set_acks, clock, reset, state_ff == S_SET2, rsp_valid_ff && (rsp_ff.status == ST_OK), "set edge gave no result")

endmodule

@@ rtl/weighted_graph_adjacency_table.sv @@
`timescale 1ns / 1ps
// Weighted undirected graph table: up to 16 vertex keys, a 16x16 weight matrix, visit marks.
// Input: a command transfers at a clock edge with start high and busy low (req_data).
// Output: each result is on rsp_data for one cycle with rsp_valid high; the receiver
// takes it there and cannot stall it. last marks the final result of a command.
// Config: csr_data (the no-edge weight) transfers when csr_valid and csr_ready are high;
// csr_ready is always high. Write it only while no command is outstanding.
// Key lookups compare all stored keys in the accept cycle; a two-entry queue feeds
// the execution side, which owns the single-port weight memory.
// Execution side: set edge makes two memory writes, read weight a registered memory
// read, and list neighbours one memory read per stored vertex. List neighbours holds
// each neighbour until the next one is found, so its final result carries the last
// one found, if any. busy rises while the queue is full and from the acceptance of a
// list command until its last result.
// Reset: empties the table, clears marks and sets every weight and the no-edge value
// to zero at once; no clearing pass.

module weighted_graph_adjacency_table
   import wgat_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  req_type                       req_data,
   output logic                          rsp_valid,
   output rsp_type                       rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic signed [WEIGHT_BITS-1:0] csr_data
);

   logic                 push;
   logic                 pop;
   logic                 empty;
   logic                 full;
   logic                 list_done;
   op_type               front_op;
   op_type               head_op;
   logic [VIDX_BITS-1:0] key_idx;
   logic [KEY_BITS-1:0]  key_data;

   assign csr_ready = 1'b1;

   wgat_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .queue_full (full),
      .push       (push),
      .op         (front_op),
      .list_done  (list_done),
      .key_idx    (key_idx),
      .key_data   (key_data)
   );

   wgat_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_op),
      .pop       (pop),
      .pop_data  (head_op),
      .empty     (empty),
      .full      (full)
   );

   wgat_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .op_valid  (!empty),
      .op        (head_op),
      .pop       (pop),
      .list_done (list_done),
      .key_idx   (key_idx),
      .key_data  (key_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ test/weighted_graph_adjacency_table_checker.sv @@
`timescale 1ns / 1ps

module weighted_graph_adjacency_table_checker
   import wgat_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  req_type                       req_data,
   input  logic                          rsp_valid,
   input  rsp_type                       rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic signed [WEIGHT_BITS-1:0] csr_data,
   output int                            mismatches,
   output int                            outstanding
);

   logic [KEY_BITS-1:0]           key_tab [MAX_VERTICES];
   int                            key_cnt;
   logic signed [WEIGHT_BITS-1:0] weights [MAX_VERTICES][MAX_VERTICES];
   bit                            marks [MAX_VERTICES];
   logic signed [WEIGHT_BITS-1:0] no_edge;
   rsp_type                       pending_results [$];
   rsp_type                       oldest;
   int                            err_cnt;

   function automatic rsp_type plain_rsp(status_type st);
      rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic bit find_vertex(input logic [KEY_BITS-1:0] key, output int idx);
      idx = 0;
      for (int i = 0; i < key_cnt; i++) begin
         if (key_tab[i] == key) begin
            idx = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic string rsp_text(rsp_type r);
      return $sformatf("status=%0d weight=%0d marked=%0b nkey=%h nvalid=%0b last=%0b",
                       r.status, r.weight_out, r.is_marked, r.neighbour_key,
                       r.neighbour_valid, r.last);
   endfunction

   function automatic bit rsp_matches(rsp_type e, rsp_type a);
      return e.status === a.status && e.weight_out === a.weight_out &&
             e.is_marked === a.is_marked && e.neighbour_key === a.neighbour_key &&
             e.neighbour_valid === a.neighbour_valid && e.last === a.last;
   endfunction

   task automatic apply_command(input req_type cmd);
      int      ia;
      int      ib;
      bit      have_held;
      rsp_type held;
      rsp_type r;
      have_held = 1'b0;
      held = '0;
      case (cmd.command)
         CMD_ADD_VERTEX: begin
            if (key_cnt >= MAX_VERTICES) begin
               pending_results.push_back(plain_rsp(ST_FULL));
            end else begin
               key_tab[key_cnt] = cmd.key_a;
               key_cnt++;
               pending_results.push_back(plain_rsp(ST_OK));
            end
         end
         CMD_SET_EDGE, CMD_READ_WEIGHT: begin
            if (!find_vertex(cmd.key_a, ia) || !find_vertex(cmd.key_b, ib)) begin
               pending_results.push_back(plain_rsp(ST_NOT_FOUND));
            end else if (cmd.command == CMD_SET_EDGE) begin
               weights[ia][ib] = cmd.edge_weight;
               weights[ib][ia] = cmd.edge_weight;
               pending_results.push_back(plain_rsp(ST_OK));
            end else begin
               r = plain_rsp(ST_OK);
               r.weight_out = weights[ia][ib];
               pending_results.push_back(r);
            end
         end
         CMD_LIST: begin
            if (!find_vertex(cmd.key_a, ia)) begin
               pending_results.push_back(plain_rsp(ST_NOT_FOUND));
            end else begin
               for (int j = 0; j < key_cnt; j++) begin
                  if (weights[ia][j] != no_edge) begin
                     if (have_held) pending_results.push_back(held);
                     held = '0;
                     held.status = ST_OK;
                     held.neighbour_key = key_tab[j];
                     held.neighbour_valid = 1'b1;
                     have_held = 1'b1;
                  end
               end
               if (have_held) begin
                  held.last = 1'b1;
                  pending_results.push_back(held);
               end else begin
                  pending_results.push_back(plain_rsp(ST_OK));
               end
            end
         end
         CMD_CLEAR_MARKS: begin
            foreach (marks[i]) marks[i] = 1'b0;
            pending_results.push_back(plain_rsp(ST_OK));
         end
         CMD_MARK, CMD_TEST_MARK: begin
            if (!find_vertex(cmd.key_a, ia)) begin
               pending_results.push_back(plain_rsp(ST_NOT_FOUND));
            end else if (cmd.command == CMD_MARK) begin
               marks[ia] = 1'b1;
               pending_results.push_back(plain_rsp(ST_OK));
            end else begin
               r = plain_rsp(ST_OK);
               r.is_marked = marks[ia];
               pending_results.push_back(r);
            end
         end
         default: begin
            key_cnt = 0;
            foreach (weights[i, j]) weights[i][j] = no_edge;
            foreach (marks[i]) marks[i] = 1'b0;
            pending_results.push_back(plain_rsp(ST_OK));
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         key_cnt = 0;
         no_edge = '0;
         foreach (weights[i, j]) weights[i][j] = '0;
         foreach (marks[i]) marks[i] = 1'b0;
         pending_results.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               err_cnt++;
               if (err_cnt <= 10)
                  $display("%0t: unexpected result %s", $realtime, rsp_text(rsp_data));
            end else begin
               oldest = pending_results.pop_front();
               if (!rsp_matches(oldest, rsp_data)) begin
                  err_cnt++;
                  if (err_cnt <= 10)
                     $display("%0t: mismatch expected %s actual %s", $realtime,
                              rsp_text(oldest), rsp_text(rsp_data));
               end
            end
         end
         if (csr_valid && csr_ready) no_edge = csr_data;
         if (start && !busy) apply_command(req_data);
      end
      mismatches <= err_cnt;
      outstanding <= pending_results.size();
   end

endmodule

@@ test/weighted_graph_adjacency_table_tb.sv @@
`timescale 1ns / 1ps

module weighted_graph_adjacency_table_tb;
   import wgat_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   req_type                       req_data;
   logic                          rsp_valid;
   rsp_type                       rsp_data;
   logic                          csr_valid;
   logic                          csr_ready;
   logic signed [WEIGHT_BITS-1:0] csr_data;
   int                            mismatches;
   int                            outstanding;
   int                            cycles;
   logic [KEY_BITS-1:0]           key_pool [$];
   logic signed [WEIGHT_BITS-1:0] cur_null;

   weighted_graph_adjacency_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   weighted_graph_adjacency_table_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("weighted_graph_adjacency_table regression: fail");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [KEY_BITS-1:0] fresh_key();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: begin
            if (key_pool.size() != 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
            return $urandom;
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [KEY_BITS-1:0] some_key();
      if (key_pool.size() != 0 && $urandom_range(0, 9) < 8)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      return fresh_key();
   endfunction

   function automatic logic signed [WEIGHT_BITS-1:0] some_weight();
      case ($urandom_range(0, 9))
         0, 1: return cur_null;
         2: return 16'sh8000;
         3: return 16'sh7fff;
         default: return WEIGHT_BITS'($urandom);
      endcase
   endfunction

   task automatic issue(input cmd_type c, input logic [KEY_BITS-1:0] ka,
                        input logic [KEY_BITS-1:0] kb,
                        input logic signed [WEIGHT_BITS-1:0] w);
      req_type r;
      int      gap;
      r.command = c;
      r.key_a = ka;
      r.key_b = kb;
      r.edge_weight = w;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      if (c == CMD_ADD_VERTEX && key_pool.size() < MAX_VERTICES) key_pool.push_back(ka);
      if (c == CMD_RESET_GRAPH) key_pool.delete();
   endtask

   // hold off until every result of the accepted commands is in
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_null(input logic signed [WEIGHT_BITS-1:0] w);
      settle();
      csr_valid <= 1'b1;
      csr_data <= w;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_null = w;
   endtask

   task automatic build_graph(input int nv);
      issue(CMD_RESET_GRAPH, $urandom, $urandom, WEIGHT_BITS'($urandom));
      repeat (nv) issue(CMD_ADD_VERTEX, fresh_key(), $urandom, WEIGHT_BITS'($urandom));
   endtask

   task automatic run_random(input int n);
      int      r;
      cmd_type c;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 3) c = CMD_RESET_GRAPH;
         else if (r < 20) c = CMD_ADD_VERTEX;
         else if (r < 40) c = CMD_SET_EDGE;
         else if (r < 53) c = CMD_READ_WEIGHT;
         else if (r < 70) c = CMD_LIST;
         else if (r < 74) c = CMD_CLEAR_MARKS;
         else if (r < 86) c = CMD_MARK;
         else c = CMD_TEST_MARK;
         if (c == CMD_ADD_VERTEX) issue(c, fresh_key(), $urandom, some_weight());
         else issue(c, some_key(), some_key(), some_weight());
         if ($urandom_range(0, 99) < 3) settle();
      end
   endtask

   task automatic directed();
      issue(CMD_LIST, 32'h0000_0001, '0, '0);
      issue(CMD_READ_WEIGHT, 32'h0000_0001, 32'h0000_0002, '0);
      issue(CMD_MARK, 32'h0000_0001, '0, '0);
      issue(CMD_TEST_MARK, 32'h0000_0001, '0, '0);
      issue(CMD_ADD_VERTEX, '0, '0, '0);
      issue(CMD_ADD_VERTEX, '1, '0, '0);
      issue(CMD_ADD_VERTEX, 32'h1234_5678, '0, '0);
      issue(CMD_ADD_VERTEX, '0, '0, '0);
      issue(CMD_SET_EDGE, '0, 32'hdead_beef, 16'sh1234);
      issue(CMD_SET_EDGE, '0, '1, 16'sh8000);
      issue(CMD_SET_EDGE, '1, '1, 16'sh7fff);
      issue(CMD_READ_WEIGHT, '0, '1, '0);
      issue(CMD_READ_WEIGHT, '1, '0, '0);
      issue(CMD_READ_WEIGHT, '0, 32'h1234_5678, '0);
      issue(CMD_LIST, '0, '0, '0);
      issue(CMD_LIST, '1, '0, '0);
      issue(CMD_LIST, 32'h1234_5678, '0, '0);
      issue(CMD_MARK, '0, '0, '0);
      issue(CMD_TEST_MARK, '0, '0, '0);
      issue(CMD_TEST_MARK, 32'h1234_5678, '0, '0);
      issue(CMD_CLEAR_MARKS, '0, '0, '0);
      issue(CMD_TEST_MARK, '0, '0, '0);
      issue(CMD_RESET_GRAPH, '0, '0, '0);
      issue(CMD_TEST_MARK, '0, '0, '0);
   endtask

   initial begin
      logic signed [WEIGHT_BITS-1:0] nulls [7];
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      cycles = 0;
      cur_null = '0;
      nulls[0] = 16'sh8000;
      nulls[1] = 16'sh7fff;
      nulls[2] = '0;
      nulls[3] = WEIGHT_BITS'($urandom);
      nulls[4] = 16'sh0001;
      nulls[5] = WEIGHT_BITS'($urandom);
      nulls[6] = -16'sh0001;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed();
      for (int p = 0; p < 7; p++) begin
         write_null(nulls[p]);
         // keep the old graph now and then so that stale no-edge entries get listed
         if (p == 0) build_graph(MAX_VERTICES + 2);
         else if ($urandom_range(0, 2) != 0) build_graph($urandom_range(1, MAX_VERTICES + 2));
         run_random(44);
      end
      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("weighted_graph_adjacency_table regression: pass");
      end else begin
         $display("weighted_graph_adjacency_table regression: fail");
      end
      $finish;
   end

endmodule
